### sv/sha256_pkg.sv
// Shared types and constants for the SHA-256 byte stream hasher.
`timescale 1ns / 1ps

package sha256_pkg;

    // Block geometry and padding constants
    localparam int          BLOCK_BYTES = 64;
    localparam int          ROUNDS      = 64;
    localparam int          DIGEST_WORDS = 8;
    localparam logic [7:0]  PAD_BYTE    = 8'h80;
    localparam logic [5:0]  LEN_OFFSET  = 6'd56;
    localparam logic [63:0] BLOCK_BITS  = 64'd512;

    // Request codes
    localparam logic REQ_ABSORB = 1'b0;
    localparam logic REQ_FINISH = 1'b1;

    // Round constants
    localparam logic [31:0] ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // Initial hash values
    localparam logic [31:0] INIT_H [DIGEST_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // Input word: one request
    typedef struct packed {
        logic       req_type;
        logic [7:0] data_byte;
    } in_item_t;

    // Output word: one digest word
    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_item_t;

    // Datapath controls from the sequencer
    typedef struct packed {
        logic       byte_shift;
        logic [7:0] byte_val;
        logic       vars_load;
        logic       round_en;
        logic [5:0] round_idx;
        logic       chain_add;
        logic       chain_init;
        logic [2:0] word_sel;
    } ctrl_t;

endpackage

### sv/sha256_sched.sv
// Block buffer and message schedule window: bytes shift in, schedule words shift out.
`timescale 1ns / 1ps

module sha256_sched (
    input  logic                aclk,
    input  sha256_pkg::ctrl_t   ctrl,
    output logic [31:0]         w_cur
);

    logic [511:0] win_reg;
    logic [511:0] win_next;
    logic [31:0]  w1;
    logic [31:0]  w9;
    logic [31:0]  w14;
    logic [31:0]  s0;
    logic [31:0]  s1;
    logic [31:0]  w_new;

    // Tap the window: word 0 is the oldest
    assign w_cur = win_reg[511:480];
    assign w1    = win_reg[479:448];
    assign w9    = win_reg[223:192];
    assign w14   = win_reg[63:32];

    // Small sigmas and next schedule word
    assign s0    = {w1[6:0], w1[31:7]} ^ {w1[17:0], w1[31:18]} ^ {3'b000, w1[31:3]};
    assign s1    = {w14[16:0], w14[31:17]} ^ {w14[18:0], w14[31:19]} ^ {10'b0, w14[31:10]};
    assign w_new = s1 + w9 + s0 + w_cur;

    // Shift a byte in on absorb, a word through on each round
    always_comb begin
        win_next = win_reg;
        if (ctrl.byte_shift) begin
            win_next = {win_reg[503:0], ctrl.byte_val};
        end else if (ctrl.round_en) begin
            win_next = {win_reg[479:0], w_new};
        end
    end

    always_ff @(posedge aclk) begin
        win_reg <= win_next;
    end

endmodule

### sv/sha256_round.sv
// Shared round unit with working variables and chaining words.
`timescale 1ns / 1ps

module sha256_round (
    input  logic                aclk,
    input  logic                aresetn,
    input  sha256_pkg::ctrl_t   ctrl,
    input  logic [31:0]         w_cur,
    output logic [31:0]         chain_word
);

    logic [31:0] vars_reg  [8];
    logic [31:0] chain_reg [8];
    logic [31:0] big_s0;
    logic [31:0] big_s1;
    logic [31:0] ch;
    logic [31:0] maj;
    logic [31:0] t1;
    logic [31:0] t2;

    // One round of compression on the working variables
    always_comb begin
        big_s1 = {vars_reg[4][5:0], vars_reg[4][31:6]} ^
                 {vars_reg[4][10:0], vars_reg[4][31:11]} ^
                 {vars_reg[4][24:0], vars_reg[4][31:25]};
        big_s0 = {vars_reg[0][1:0], vars_reg[0][31:2]} ^
                 {vars_reg[0][12:0], vars_reg[0][31:13]} ^
                 {vars_reg[0][21:0], vars_reg[0][31:22]};
        ch     = (vars_reg[4] & vars_reg[5]) ^ (~vars_reg[4] & vars_reg[6]);
        maj    = (vars_reg[0] & vars_reg[1]) ^ (vars_reg[0] & vars_reg[2]) ^
                 (vars_reg[1] & vars_reg[2]);
        t1     = vars_reg[7] + big_s1 + ch + sha256_pkg::ROUND_K[ctrl.round_idx] + w_cur;
        t2     = big_s0 + maj;
    end

    // Load, advance the working variables
    always_ff @(posedge aclk) begin
        if (ctrl.vars_load) begin
            for (int i = 0; i < 8; i++) begin
                vars_reg[i] <= chain_reg[i];
            end
        end else if (ctrl.round_en) begin
            vars_reg[7] <= vars_reg[6];
            vars_reg[6] <= vars_reg[5];
            vars_reg[5] <= vars_reg[4];
            vars_reg[4] <= vars_reg[3] + t1;
            vars_reg[3] <= vars_reg[2];
            vars_reg[2] <= vars_reg[1];
            vars_reg[1] <= vars_reg[0];
            vars_reg[0] <= t1 + t2;
        end
    end

    // Fold the block into the chaining words; restart on a new message
    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.chain_init) begin
            for (int i = 0; i < 8; i++) begin
                chain_reg[i] <= sha256_pkg::INIT_H[i];
            end
        end else if (ctrl.chain_add) begin
            for (int i = 0; i < 8; i++) begin
                chain_reg[i] <= chain_reg[i] + vars_reg[i];
            end
        end
    end

    assign chain_word = chain_reg[ctrl.word_sel];

endmodule

### sv/sha256_byte_stream_hasher.sv
// Top level of the SHA-256 byte stream hasher: sequencer, counters and ports.
`timescale 1ns / 1ps

// Channel  Ports                        Word
// input    s_valid s_ready s_data       req_type, data_byte
// output   m_valid m_ready m_data       digest_word, word_index, last_word
//
// Absorb words are taken back to back; every 64th byte starts a compression (load, 64 rounds
// through the shared round unit, chaining update) with s_ready low.
// A finish with n bytes pending feeds 64-n pad bytes one a cycle, then compresses
// (with a second 64-byte feed and compression when n >= 56), then emits eight words.
// Reset is synchronous on aresetn and restores the initial hash values.
// Output words wait on m_ready indefinitely; no input is taken until the eighth
// digest word is accepted.

module sha256_byte_stream_hasher (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  sha256_pkg::in_item_t    s_data,
    output logic                    m_valid,
    input  logic                    m_ready,
    output sha256_pkg::out_item_t   m_data
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_FEED   = 3'd1;
    localparam logic [2:0] ST_LOAD   = 3'd2;
    localparam logic [2:0] ST_ROUND  = 3'd3;
    localparam logic [2:0] ST_UPDATE = 3'd4;
    localparam logic [2:0] ST_OUT    = 3'd5;

    logic [2:0]  state_reg,  state_next;
    logic [5:0]  fill_reg,   fill_next;
    logic [63:0] bitlen_reg, bitlen_next;
    logic [63:0] len_reg,    len_next;
    logic        mark_reg,   mark_next;
    logic        len_ok_reg, len_ok_next;
    logic        fin_reg,    fin_next;
    logic        final_reg,  final_next;
    logic [5:0]  rnd_reg,    rnd_next;
    logic [2:0]  idx_reg,    idx_next;

    sha256_pkg::ctrl_t ctrl;
    logic [31:0]       w_cur;
    logic [31:0]       chain_word;
    logic              in_fire;
    logic              out_fire;
    logic              len_phase;

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = (state_reg == ST_OUT);
    assign in_fire   = s_valid && s_ready;
    assign out_fire  = m_valid && m_ready;
    assign len_phase = len_ok_reg && (fill_reg >= sha256_pkg::LEN_OFFSET);

    // Sequence absorb, padding, compression and digest output
    always_comb begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        bitlen_next = bitlen_reg;
        len_next    = len_reg;
        mark_next   = mark_reg;
        len_ok_next = len_ok_reg;
        fin_next    = fin_reg;
        final_next  = final_reg;
        rnd_next    = rnd_reg;
        idx_next    = idx_reg;

        ctrl            = '0;
        ctrl.round_idx  = rnd_reg;
        ctrl.word_sel   = idx_reg;

        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    if (s_data.req_type == sha256_pkg::REQ_ABSORB) begin
                        ctrl.byte_shift = 1'b1;
                        ctrl.byte_val   = s_data.data_byte;
                        fill_next       = fill_reg + 6'd1;
                        fin_next        = 1'b0;
                        if (fill_reg == 6'd63) begin
                            state_next = ST_LOAD;
                        end
                    end else begin
                        len_next    = bitlen_reg + {55'b0, fill_reg, 3'b000};
                        mark_next   = 1'b0;
                        len_ok_next = (fill_reg < sha256_pkg::LEN_OFFSET);
                        fin_next    = 1'b1;
                        state_next  = ST_FEED;
                    end
                end
            end
            ST_FEED: begin
                ctrl.byte_shift = 1'b1;
                if (!mark_reg) begin
                    ctrl.byte_val = sha256_pkg::PAD_BYTE;
                end else if (len_phase) begin
                    ctrl.byte_val = len_reg[63:56];
                end else begin
                    ctrl.byte_val = 8'h00;
                end
                if (mark_reg && len_phase) begin
                    len_next = {len_reg[55:0], 8'h00};
                end
                mark_next = 1'b1;
                fill_next = fill_reg + 6'd1;
                if (fill_reg == 6'd63) begin
                    final_next = len_ok_reg;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                ctrl.vars_load = 1'b1;
                rnd_next       = 6'd0;
                state_next     = ST_ROUND;
            end
            ST_ROUND: begin
                ctrl.round_en = 1'b1;
                rnd_next      = rnd_reg + 6'd1;
                if (rnd_reg == 6'd63) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                ctrl.chain_add = 1'b1;
                if (!fin_reg) begin
                    bitlen_next = bitlen_reg + sha256_pkg::BLOCK_BITS;
                    state_next  = ST_IDLE;
                end else if (final_reg) begin
                    idx_next   = 3'd0;
                    state_next = ST_OUT;
                end else begin
                    len_ok_next = 1'b1;
                    state_next  = ST_FEED;
                end
            end
            ST_OUT: begin
                if (out_fire) begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7) begin
                        ctrl.chain_init = 1'b1;
                        fill_next       = 6'd0;
                        bitlen_next     = 64'd0;
                        fin_next        = 1'b0;
                        state_next      = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold control state; clear on reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            fill_reg   <= 6'd0;
            bitlen_reg <= 64'd0;
            mark_reg   <= 1'b0;
            len_ok_reg <= 1'b0;
            fin_reg    <= 1'b0;
            final_reg  <= 1'b0;
            rnd_reg    <= 6'd0;
            idx_reg    <= 3'd0;
        end else begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            bitlen_reg <= bitlen_next;
            mark_reg   <= mark_next;
            len_ok_reg <= len_ok_next;
            fin_reg    <= fin_next;
            final_reg  <= final_next;
            rnd_reg    <= rnd_next;
            idx_reg    <= idx_next;
        end
    end

    // Hold the length bytes being fed
    always_ff @(posedge aclk) begin
        len_reg <= len_next;
    end

    sha256_sched u_sched (
        .aclk   (aclk),
        .ctrl   (ctrl),
        .w_cur  (w_cur)
    );

    sha256_round u_round (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (ctrl),
        .w_cur      (w_cur),
        .chain_word (chain_word)
    );

    // Drive the output word
    assign m_data.digest_word = chain_word;
    assign m_data.word_index  = idx_reg;
    assign m_data.last_word   = (idx_reg == 3'd7);

    // Never take input while a digest word is pending
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input accepted while digest pending");

    // A block starts compression only with a full buffer
    a_load_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOAD) |-> (fill_reg == 6'd0))
        else $error("compression started on partial block");

    // The last round hands over to the chaining update
    a_round_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROUND && rnd_reg == 6'd63) |=> (state_reg == ST_UPDATE))
        else $error("round count overran");

    // The final digest word restarts the message
    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_fire && m_data.last_word) |=>
            (state_reg == ST_IDLE && bitlen_reg == 64'd0 && fill_reg == 6'd0))
        else $error("message state not cleared after digest");

endmodule

### test/sha256_byte_stream_hasher_test.sv
// Self-checking testbench for the SHA-256 byte stream hasher with a built-in hash predictor.
`timescale 1ns / 1ps

module sha256_byte_stream_hasher_test;

    localparam int STALL_LIMIT  = 4000;  // cycles with no word moving on either side
    localparam int SETTLE_TAIL  = 300;   // covers the longest finish sequence
    localparam int WORD_BUDGET  = 460;
    localparam logic [7:0] PAD_MARK = 8'h80;

    // Round constants, kept apart from the design's own table
    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] SHA_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    sha256_pkg::in_item_t  s_data  = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    sha256_pkg::out_item_t m_data;

    // Predicted hash state
    logic [31:0]           chain_words [8];
    logic [7:0]            block_bytes [64];
    logic [5:0]            block_fill;
    logic [63:0]           message_bits;
    sha256_pkg::out_item_t pending_digest_words [$];

    int  fail_count      = 0;
    int  words_sent      = 0;
    int  messages_closed = 0;
    int  digest_checked  = 0;
    int  idle_cycles     = 0;
    bit  input_gaps      = 1'b1;

    sha256_byte_stream_hasher u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #2 aclk = ~aclk;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // Fold the current 64-byte block into the chaining words
    function automatic void compress_block();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h;
        logic [31:0] s0, s1, t1, t2;
        int i;
        for (i = 0; i < 16; i++) begin
            w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
        end
        for (i = 16; i < 64; i++) begin
            s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
        end
        a = chain_words[0]; b = chain_words[1]; c = chain_words[2]; d = chain_words[3];
        e = chain_words[4]; f = chain_words[5]; g = chain_words[6]; h = chain_words[7];
        for (i = 0; i < 64; i++) begin
            t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
                 + SHA_K[i] + w[i];
            t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        chain_words[0] += a; chain_words[1] += b; chain_words[2] += c; chain_words[3] += d;
        chain_words[4] += e; chain_words[5] += f; chain_words[6] += g; chain_words[7] += h;
    endfunction

    function automatic void restart_message();
        chain_words  = SHA_IV;
        block_fill   = '0;
        message_bits = '0;
    endfunction

    // Advance the predicted state by one accepted request; queue the digest on finish
    function automatic void predict_hash_update(input sha256_pkg::in_item_t req);
        int                    fill;
        logic [63:0]           total;
        sha256_pkg::out_item_t word;
        int                    i;
        if (req.req_type == sha256_pkg::REQ_ABSORB) begin
            block_bytes[block_fill] = req.data_byte;
            block_fill = block_fill + 6'd1;
            if (block_fill == '0) begin
                compress_block();
                message_bits = message_bits + 64'd512;
            end
        end else begin
            fill  = int'(block_fill);
            total = message_bits + 64'(fill) * 64'd8;
            block_bytes[fill] = PAD_MARK;
            for (i = fill + 1; i < 64; i++) block_bytes[i] = 8'h00;
            // no room for the length field: spill into a second block
            if (fill >= 56) begin
                compress_block();
                for (i = 0; i < 56; i++) block_bytes[i] = 8'h00;
            end
            for (i = 0; i < 8; i++) block_bytes[56+i] = total[63-8*i -: 8];
            compress_block();
            for (i = 0; i < 8; i++) begin
                word.digest_word = chain_words[i];
                word.word_index  = 3'(i);
                word.last_word   = (i == 7);
                pending_digest_words.push_back(word);
            end
            restart_message();
            messages_closed++;
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!input_gaps || r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Offer one request word and hold it until accepted
    task automatic send_word(input logic kind, input logic [7:0] value);
        sha256_pkg::in_item_t word;
        int                   gap;
        word.req_type  = kind;
        word.data_byte = value;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= word;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        predict_hash_update(word);
        words_sent++;
    endtask

    task automatic send_random_message(input int len);
        int i;
        for (i = 0; i < len; i++) begin
            send_word(sha256_pkg::REQ_ABSORB, 8'($urandom_range(0, 255)));
        end
        send_word(sha256_pkg::REQ_FINISH, 8'($urandom_range(0, 255)));
    endtask

    // Drop valid and wait for every predicted digest word to come out
    task automatic drain_digests();
        s_valid <= 1'b0;
        do begin
            @(posedge aclk);
        end while (pending_digest_words.size() != 0);
    endtask

    // Empty message, one-byte extremes, the classic three-byte vector, repeated finishes
    task automatic test_short_messages();
        send_word(sha256_pkg::REQ_FINISH, 8'hff);
        send_word(sha256_pkg::REQ_ABSORB, 8'h00);
        send_word(sha256_pkg::REQ_FINISH, 8'h00);
        send_word(sha256_pkg::REQ_ABSORB, 8'hff);
        send_word(sha256_pkg::REQ_FINISH, 8'hff);
        send_word(sha256_pkg::REQ_ABSORB, 8'h61);
        send_word(sha256_pkg::REQ_ABSORB, 8'h62);
        send_word(sha256_pkg::REQ_ABSORB, 8'h63);
        send_word(sha256_pkg::REQ_FINISH, 8'h5a);
        send_word(sha256_pkg::REQ_FINISH, 8'ha5);
        send_word(sha256_pkg::REQ_FINISH, 8'h00);
        drain_digests();
    endtask

    // Lengths around the length-field boundary and a full block; the first two are sent back to back
    task automatic test_pad_boundaries();
        input_gaps = 1'b0;
        send_random_message(55);
        send_random_message(56);
        input_gaps = 1'b1;
        send_random_message(63);
        send_random_message(64);
        drain_digests();
    endtask

    // Random messages, mostly short, until the word budget is used up
    task automatic test_random_messages();
        int r;
        int len;
        while (words_sent < WORD_BUDGET) begin
            r = $urandom_range(0, 99);
            if (r < 70)      len = $urandom_range(0, 12);
            else if (r < 90) len = $urandom_range(13, 40);
            else             len = $urandom_range(41, 70);
            send_random_message(len);
        end
        drain_digests();
    endtask

    function automatic void flag_field(input string field, input logic [31:0] want,
                                       input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
            fail_count++;
        end
    endfunction

    // Check each digest word against the oldest prediction
    always @(posedge aclk) begin
        sha256_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_digest_words.size() == 0) begin
                $display("%0t: unexpected digest word, expected none, actual %h/%0d/%0b",
                         $time, m_data.digest_word, m_data.word_index, m_data.last_word);
                fail_count++;
            end else begin
                want = pending_digest_words.pop_front();
                flag_field("digest_word", want.digest_word, m_data.digest_word);
                flag_field("word_index", 32'(want.word_index), 32'(m_data.word_index));
                flag_field("last_word", 32'(want.last_word), 32'(m_data.last_word));
                digest_checked++;
            end
        end
    end

    // Abort when nothing moves for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: timeout, no word moved for %0d cycles", $time, idle_cycles);
                $display("** sha256_byte_stream_hasher: FAILED **");
                $finish;
            end
        end
    end

    // Throttle the result side: short stalls, a few long ones, some stall-free stretches
    initial begin
        int on_len;
        int off_len;
        int r;
        while (!aresetn) @(posedge aclk);
        forever begin
            on_len = ($urandom_range(0, 99) < 15) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 8);
            r = $urandom_range(0, 99);
            off_len = (r < 50) ? 0 : (r < 90) ? $urandom_range(1, 4) : $urandom_range(20, 60);
            m_ready <= 1'b1;
            repeat (on_len) @(posedge aclk);
            if (off_len > 0) begin
                m_ready <= 1'b0;
                repeat (off_len) @(posedge aclk);
            end
        end
    end

    initial begin
        restart_message();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_short_messages();
        test_pad_boundaries();
        test_random_messages();
        repeat (SETTLE_TAIL) @(posedge aclk);
        $display("Sent %0d request words closing %0d messages (empty, pad boundaries, random).",
                 words_sent, messages_closed);
        $display("Checked %0d digest words, %0d mismatches.", digest_checked, fail_count);
        if (fail_count == 0 && pending_digest_words.size() == 0) begin
            $display("** sha256_byte_stream_hasher: PASSED **");
        end else begin
            $display("** sha256_byte_stream_hasher: FAILED **");
        end
        $finish;
    end

endmodule
